@@ hw/rtl/tmts_pkg.sv @@
package tmts_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int WEIGHT_W         = 9;
  localparam int FILL_W           = 4;
  localparam int Q_BITS           = 8;
  localparam int WINDOW_DEPTH_DEF = 11;
  localparam int TRIM_THRESHOLD   = 5;
  // two smallest plus two largest
  localparam int TRIM_DROP        = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd26;

  typedef struct packed {
    logic load;
    logic scan;
    logic div_init;
    logic div_step;
    logic mul;
    logic finish;
  } tmts_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_last;
    logic out_free;
  } tmts_sts_t;

endpackage

@@ hw/rtl/tmts_ifs.sv @@
interface tmts_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmts_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tmts_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmts_pkg::SAMPLE_W-1:0] smoothed;
  logic [tmts_pkg::FILL_W-1:0]   window_fill;
  modport source (output valid, output smoothed, output window_fill, input ready);
  modport sink (input valid, input smoothed, input window_fill, output ready);
endinterface

interface tmts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tmts_pkg::WEIGHT_W-1:0] blend_weight;
  modport source (output valid, output blend_weight, input ready);
  modport sink (input valid, input blend_weight, output ready);
endinterface

@@ hw/rtl/trimmed_mean_time_step_smoother_unit.sv @@
// Trimmed-mean time step smoother.
// Channels: in_ch carries one sample word, out_ch one smoothed word plus the
// window fill, cfg_ch writes the Q8 blend weight (always ready, reset 26;
// values above 256 act as 256). Write the weight only while the block is idle.
// Each sample is written into a ring of WINDOW_DEPTH entries; the window is
// then scanned one entry a cycle to form the sum and the two smallest and two
// largest values. With more than five samples those four are dropped. A
// restoring divider (one quotient bit a cycle) forms the mean, and two
// multipliers blend it with the newest sample.
// From accept to out_ch.valid a sample passes the scan, the divide (SW quotient
// bits, SW = 24 + clog2(WINDOW_DEPTH), 28 at depth 11), the two multipliers and
// the final sum, which waits for a free output register.
// One sample is in work at a time; in_ch.ready is high whenever no sample is
// in work, also while a finished word still waits on out_ch.
// A stalled receiver holds the result in the output register; the next
// result waits in the datapath until that register frees.
// Reset (rst_n low, synchronous) empties the window, clears the ring pointer
// and the output valid, and restores the weight.
module trimmed_mean_time_step_smoother_unit #(
  parameter int WINDOW_DEPTH = tmts_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tmts_in_if.sink     in_ch,
  tmts_out_if.source  out_ch,
  tmts_cfg_if.sink    cfg_ch
);
  import tmts_pkg::*;

  tmts_cmd_t cmd;
  tmts_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tmts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmts_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (in_ch.sample),
    .cfg_we       (cfg_ch.valid),
    .cfg_data     (cfg_ch.blend_weight),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_smoothed (out_ch.smoothed),
    .out_fill     (out_ch.window_fill)
  );

endmodule

@@ hw/rtl/tmts_ctrl.sv @@
module tmts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tmts_pkg::tmts_sts_t   sts,
  output tmts_pkg::tmts_cmd_t   cmd
);
  import tmts_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_SUM  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  property p_div_after_scan;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_DIV) |-> ($past(state_r) == ST_SCAN || $past(state_r) == ST_DIV);
  endproperty
  a_div_after_scan: assert property (p_div_after_scan)
    else $error("divide entered without a finished scan");

  property p_load_only_idle;
    @(posedge clk) disable iff (!rst_n)
      cmd.load |=> (state_r == ST_SCAN);
  endproperty
  a_load_only_idle: assert property (p_load_only_idle)
    else $error("load did not start a scan");

  property p_finish_to_idle;
    @(posedge clk) disable iff (!rst_n)
      cmd.finish |=> in_ready;
  endproperty
  a_finish_to_idle: assert property (p_finish_to_idle)
    else $error("not ready after finishing a word");

endmodule

@@ hw/rtl/tmts_dp.sv @@
module tmts_dp #(
  parameter int WINDOW_DEPTH = tmts_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmts_pkg::tmts_cmd_t           cmd,
  output tmts_pkg::tmts_sts_t           sts,
  input  logic [tmts_pkg::SAMPLE_W-1:0] sample,
  input  logic                          cfg_we,
  input  logic [tmts_pkg::WEIGHT_W-1:0] cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tmts_pkg::SAMPLE_W-1:0] out_smoothed,
  output logic [tmts_pkg::FILL_W-1:0]   out_fill
);
  import tmts_pkg::*;

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int DCW = $clog2(SW);
  localparam int PW  = WEIGHT_W + SAMPLE_W;

  logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];

  logic [WEIGHT_W-1:0] weight_r;
  logic [SAMPLE_W-1:0] newest_r;
  logic [CW-1:0]       fill_r;
  logic [AW-1:0]       slot_r;
  logic [CW-1:0]       rd_idx_r;
  logic                rd_vld_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SW-1:0]       sum_r;
  logic [SAMPLE_W-1:0] mn0_r, mn1_r, mx0_r, mx1_r;
  logic [SW-1:0]       q_r;
  logic [CW-1:0]       rem_r;
  logic [CW-1:0]       den_r;
  logic [DCW-1:0]      div_cnt_r;
  logic [PW-1:0]       p_mean_r, p_new_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] smoothed_r;
  logic [FILL_W-1:0]   fill_out_r;

  logic                rd_more;
  logic                trim;
  logic [SW-1:0]       trimmed;
  logic [CW:0]         trial;
  logic [CW:0]         diff;
  logic                qbit;
  logic [WEIGHT_W-1:0] w_sat;
  logic [WEIGHT_W-1:0] w_inv;
  logic [PW-1:0]       blend_sum;
  logic [CW+FILL_W-1:0] fill_wide;

  assign rd_more = (rd_idx_r < fill_r);
  assign trim    = (fill_r > CW'(TRIM_THRESHOLD));
  assign trimmed = sum_r - (SW'(mn0_r) + SW'(mn1_r)) - (SW'(mx0_r) + SW'(mx1_r));
  assign trial   = {rem_r, q_r[SW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign qbit    = (trial >= {1'b0, den_r});
  assign w_sat   = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_inv   = WEIGHT_ONE - w_sat;
  assign blend_sum = p_mean_r + p_new_r;
  assign fill_wide = {{FILL_W{1'b0}}, fill_r};

  assign sts.scan_done = !rd_more && !rd_vld_r;
  assign sts.div_last  = (div_cnt_r == DCW'(SW - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_smoothed = smoothed_r;
  assign out_fill     = fill_out_r;

  // window memory: one write at load, one registered read per scan cycle while entries remain
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[slot_r] <= sample;
    end
    if (cmd.scan && rd_more) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= WEIGHT_RESET;
      fill_r      <= '0;
      slot_r      <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight_r <= cfg_data;
      end
      if (cmd.load) begin
        slot_r   <= (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (fill_r != CW'(WINDOW_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
        rd_idx_r <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld_r <= rd_more;
        if (rd_more) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sum and two-deep min/max tracking over the scanned entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      newest_r <= sample;
      sum_r    <= '0;
      mn0_r    <= '1;
      mn1_r    <= '1;
      mx0_r    <= '0;
      mx1_r    <= '0;
    end else if (cmd.scan && rd_vld_r) begin
      sum_r <= sum_r + SW'(rd_data_r);
      if (rd_data_r < mn0_r) begin
        mn1_r <= mn0_r;
        mn0_r <= rd_data_r;
      end else if (rd_data_r < mn1_r) begin
        mn1_r <= rd_data_r;
      end
      if (rd_data_r > mx0_r) begin
        mx1_r <= mx0_r;
        mx0_r <= rd_data_r;
      end else if (rd_data_r > mx1_r) begin
        mx1_r <= rd_data_r;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r       <= trim ? trimmed : sum_r;
      den_r     <= trim ? fill_r - CW'(TRIM_DROP) : fill_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[SW-2:0], qbit};
      rem_r     <= qbit ? diff[CW-1:0] : trial[CW-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_mean_r <= PW'(w_sat) * PW'(q_r[SAMPLE_W-1:0]);
      p_new_r  <= PW'(w_inv) * PW'(newest_r);
    end
    if (cmd.finish) begin
      smoothed_r <= blend_sum[SAMPLE_W+Q_BITS-1:Q_BITS];
      fill_out_r <= fill_wide[FILL_W-1:0];
    end
  end

  property p_finish_when_free;
    @(posedge clk) disable iff (!rst_n)
      cmd.finish |-> (!out_valid_r || out_ready);
  endproperty
  a_finish_when_free: assert property (p_finish_when_free)
    else $error("output word overwritten before it was taken");

  property p_read_in_range;
    @(posedge clk) disable iff (!rst_n)
      (cmd.scan && rd_more) |-> (rd_idx_r < CW'(WINDOW_DEPTH));
  endproperty
  a_read_in_range: assert property (p_read_in_range)
    else $error("window read beyond depth");

  property p_scan_covers_fill;
    @(posedge clk) disable iff (!rst_n)
      cmd.div_init |-> (rd_idx_r == fill_r && fill_r != '0);
  endproperty
  a_scan_covers_fill: assert property (p_scan_covers_fill)
    else $error("divide started before all entries were summed");

  property p_single_passthrough;
    @(posedge clk) disable iff (!rst_n)
      (cmd.finish && fill_r == CW'(1)) |=> (smoothed_r == $past(newest_r));
  endproperty
  a_single_passthrough: assert property (p_single_passthrough)
    else $error("single sample not passed through");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tmts_pkg::*;

  localparam int DEPTH       = WINDOW_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic [FILL_W-1:0]   window_fill;
  } smooth_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tmts_in_if  in_ch();
  tmts_out_if out_ch();
  tmts_cfg_if cfg_ch();

  trimmed_mean_time_step_smoother_unit #(
    .WINDOW_DEPTH(DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // window model
  logic [SAMPLE_W-1:0] ring [DEPTH];
  int unsigned         held = 0;
  int unsigned         next_slot = 0;
  logic [WEIGHT_W-1:0] weight_now = WEIGHT_RESET;

  smooth_word_t        expected_words [$];
  int unsigned         mismatch_count = 0;
  int unsigned         idle_cycles = 0;
  bit                  quiet = 1'b0;
  int unsigned         gap_odds = 4;
  int unsigned         hold_request = 0;
  logic [SAMPLE_W-1:0] cluster_base = 24'h400000;
  logic [SAMPLE_W-1:0] last_sample = '0;

  always #6 clk = ~clk;

  function automatic smooth_word_t smooth_sample(input logic [SAMPLE_W-1:0] fresh);
    logic [SAMPLE_W-1:0] sorted [DEPTH];
    logic [SAMPLE_W-1:0] key;
    logic [31:0]         total;
    logic [31:0]         kept;
    logic [31:0]         avg;
    logic [WEIGHT_W-1:0] w_eff;
    logic [40:0]         mix;
    int                  lo;
    int                  hi;
    int                  i;
    int                  j;
    smooth_word_t        word;
    ring[next_slot] = fresh;
    next_slot = (next_slot + 1) % DEPTH;
    if (held < DEPTH) held++;
    word.window_fill = held[FILL_W-1:0];
    if (held == 1) begin
      word.smoothed = fresh;
      return word;
    end
    for (i = 0; i < held; i++) sorted[i] = ring[i];
    lo = 0;
    hi = held;
    if (held > TRIM_THRESHOLD) begin
      for (i = 1; i < held; i++) begin
        key = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      // drop two at each end
      lo = TRIM_DROP / 2;
      hi = held - TRIM_DROP / 2;
    end
    total = '0;
    for (i = lo; i < hi; i++) total = total + {8'd0, sorted[i]};
    kept = hi - lo;
    avg = total / kept;
    w_eff = (weight_now > WEIGHT_ONE) ? WEIGHT_ONE : weight_now;
    mix = {32'd0, w_eff} * {9'd0, avg} + {32'd0, WEIGHT_ONE - w_eff} * {17'd0, fresh};
    word.smoothed = mix[Q_BITS +: SAMPLE_W];
    return word;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned         roll;
    logic [31:0]         rnd;
    logic [SAMPLE_W-1:0] value;
    roll = $urandom_range(0, 9);
    rnd = $urandom;
    if (roll < 5) begin
      value = rnd[SAMPLE_W-1:0];
    end else if (roll < 7) begin
      value = cluster_base + {12'd0, rnd[11:0]};
    end else if (roll == 7) begin
      value = '0;
      value[3:0] = rnd[3:0];
    end else if (roll == 8) begin
      value = '1;
      value[3:0] = rnd[3:0];
    end else begin
      value = last_sample;
    end
    last_sample = value;
    return value;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return WEIGHT_ONE;
      2: return '1;
      3: return WEIGHT_ONE + 9'd1;
      default: return WEIGHT_W'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_words
    smooth_word_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) weight_now = cfg_ch.blend_weight;
      if (in_ch.valid && in_ch.ready)
        expected_words = {expected_words, smooth_sample(in_ch.sample)};
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", {8'd0, out_ch.smoothed}, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.smoothed !== want.smoothed)
            report_mismatch("smoothed", {8'd0, out_ch.smoothed}, {8'd0, want.smoothed});
          if (out_ch.window_fill !== want.window_fill)
            report_mismatch("window_fill", {28'd0, out_ch.window_fill},
                            {28'd0, want.window_fill});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random ready bursts, plus a long hold when asked
  initial begin : receiver
    int unsigned span;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request != 0) begin
        span = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
      end else begin
        span = quiet ? 1 : $urandom_range(1, 16);
        out_ch.ready <= 1'b1;
      end
      repeat (span) @(negedge clk);
    end
  end

  // leaves valid high; drain_results or a random gap in the next send lowers it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.blend_weight <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // reset weight; single sample, untrimmed small window, full window, wrap
  task automatic test_window_fill();
    logic [SAMPLE_W-1:0] opening [13] = '{
      24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h800000, 24'h000001,
      24'hFFFFFE, 24'h555555, 24'hAAAAAA, 24'h00000C, 24'hFFFFFF, 24'h000001,
      24'h7FFFFF};
    foreach (opening[k]) send_sample(opening[k]);
    drain_results();
  endtask

  // zero, one, saturating and odd weights
  task automatic test_weight_extremes();
    logic [WEIGHT_W-1:0] weights [5] = '{9'd0, WEIGHT_ONE, 9'h1FF, 9'd257, 9'd1};
    foreach (weights[k]) begin
      write_weight(weights[k]);
      send_sample(24'hFFFFFF);
      send_sample(24'h000000);
      drain_results();
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      write_weight(pick_weight());
      gap_odds = (p % 3 == 2) ? 0 : $urandom_range(2, 6);
      cluster_base = SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain_results();
    end
    gap_odds = 4;
  endtask

  // hold the receiver while samples keep coming, so the input stalls
  task automatic test_stalled_receiver();
    hold_request = 400;
    repeat (6) send_sample(pick_sample());
    drain_results();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    write_weight(pick_weight());
    repeat (60) send_sample(pick_sample());
    drain_results();
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.blend_weight = WEIGHT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_window_fill();
    test_weight_extremes();
    test_random_phases();
    test_stalled_receiver();
    test_quiet_tail();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tmts_pkg.sv
hw/rtl/tmts_ifs.sv
hw/rtl/tmts_ctrl.sv
hw/rtl/tmts_dp.sv
hw/rtl/trimmed_mean_time_step_smoother_unit.sv
verif/tb.sv
